### rtl/core/scm_pkg.sv
// Shared types, constants and arithmetic helpers for the sponge and causal mask block.
// No dependencies; used by scm_isqrt and sponge_causal_mask_apply.
`timescale 1ns / 1ps
`default_nettype none
package scm_pkg;

    localparam int MAX_GRID        = 1024;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [15:0] HALF_Q16 = 16'd32768;

    // Square root: 56-bit radicand, two result bits per stage.
    localparam int SQ_IN_W  = 56;
    localparam int SQ_RT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_RT_W + 2;
    localparam int SQ_STG   = SQ_RT_W / 2;

    typedef struct packed {
        logic [9:0]         depth_index;
        logic [9:0]         lateral_index;
        logic [11:0]        time_index;
        logic signed [31:0] sample_value;
        logic signed [31:0] prior_value;
        logic               accumulate;
        logic [11:0]        start_delay_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] masked_value;
        logic [16:0]        mask_coefficient;
    } t_out_item;

    // Per-item data that rides along the square-root pipeline.
    typedef struct packed {
        logic [11:0]        time_index;
        logic [11:0]        start_delay;
        logic signed [31:0] sample_value;
        logic signed [31:0] prior_value;
        logic               accumulate;
        logic [16:0]        edge_coef;
    } t_side;

    typedef logic [EXP_TABLE_DEPTH-1:0][16:0] t_exp_tab;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_RT_W-1:0]  root;
    } t_sq_state;

    // Exp table built at elaboration: entry i approximates exp(-i/16) in Q1.16.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] v;
        logic [63:0] r;
        v = 64'd1 << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            r = (v + 64'd32768) >> 16;
            tab[i] = r[16:0];
            v = (v * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    // Table lookup of a Q.16 taper argument; big marks a distance term over 2047.
    function automatic logic [16:0] taper_lookup(input logic [37:0] arg, input logic big,
                                                 input logic rate_nz);
        logic [38:0] idx;
        idx = ({1'b0, arg} + 39'd2048) >> 12;
        if (big) begin
            return rate_nz ? 17'd0 : EXP_TAB[0];
        end else if (idx >= 39'(EXP_TABLE_DEPTH)) begin
            return 17'd0;
        end else begin
            return EXP_TAB[idx[EXP_IDX_W-1:0]];
        end
    endfunction

    // One digit-by-digit square-root step that brings in two radicand bits.
    function automatic t_sq_state sqrt_step(input t_sq_state st, input logic [1:0] xb);
        t_sq_state           res;
        logic [SQ_REM_W-1:0] rem_n;
        logic [SQ_REM_W-1:0] trial;
        rem_n = {st.rem[SQ_REM_W-3:0], xb};
        trial = {st.root, 2'b01};
        if (rem_n >= trial) begin
            res.rem  = rem_n - trial;
            res.root = {st.root[SQ_RT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_n;
            res.root = {st.root[SQ_RT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/scm_isqrt.sv
// Pipelined integer square root (floor), two result bits per stage, with sideband.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scm_isqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [scm_pkg::SQ_IN_W-1:0]    i_radicand,
    input  wire scm_pkg::t_side                 i_side,
    output logic                                o_valid,
    output logic [scm_pkg::SQ_RT_W-1:0]         o_root,
    output scm_pkg::t_side                      o_side
);
    import scm_pkg::*;

    logic                 r_vld  [SQ_STG];
    logic [SQ_IN_W-1:0]   r_x    [SQ_STG];
    t_sq_state            r_st   [SQ_STG];
    t_side                r_side [SQ_STG];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stage
        logic               p_vld;
        logic [SQ_IN_W-1:0] p_x;
        t_sq_state          p_st;
        t_side              p_side;
        t_sq_state          n_mid;
        t_sq_state          n_st;

        // Stage inputs come from the port for the first stage, else from the previous one.
        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_x    = i_radicand;
            assign p_st   = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_x    = r_x[g-1];
            assign p_st   = r_st[g-1];
            assign p_side = r_side[g-1];
        end

        // Two dependent steps per stage.
        always_comb begin
            n_mid = sqrt_step(p_st, p_x[SQ_IN_W-1 -: 2]);
            n_st  = sqrt_step(n_mid, p_x[SQ_IN_W-3 -: 2]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= {p_x[SQ_IN_W-5:0], 4'b0000};
                r_st[g]   <= n_st;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[SQ_STG-1];
    assign o_root  = r_st[SQ_STG-1].root;
    assign o_side  = r_side[SQ_STG-1];

endmodule
`default_nettype wire

### rtl/core/sponge_causal_mask_apply.sv
// Top level of the Gaussian edge sponge and causal mute mask applied per sample.
// Depends on scm_pkg and scm_isqrt.
//
// Use: each input item carries one wavefield sample with its depth, lateral and
// time indices, a prior value, an accumulate flag and the onset delay. Each item
// gives exactly one result item: the masked (and optionally accumulated) sample,
// saturated to Q16.16, and the Q1.16 coefficient that was applied.
// Channels are valid/ready; configuration is a plain write port (enable, index,
// data); the user must write it only while no item is in flight, as the block does not enforce it.
// From input accept to output valid the pipeline has four front stages,
// fourteen square-root stages (two root bits each) and seven stages for the
// causal taper, coefficient product, sample product and saturation.
// Throughput is one item per cycle. The whole pipeline advances together; when
// the receiver holds ready low with a result waiting in the output register, the
// pipeline freezes and input ready drops, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and sets the registers to
// their defaults: grid sizes 1024, all others zero.
`timescale 1ns / 1ps
`default_nettype none
module sponge_causal_mask_apply (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire scm_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output scm_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import scm_pkg::*;

    localparam logic [2:0] REG_GRID_DEPTH   = 3'd0;
    localparam logic [2:0] REG_GRID_LATERAL = 3'd1;
    localparam logic [2:0] REG_SPONGE_WIDTH = 3'd2;
    localparam logic [2:0] REG_TAPER_RATE   = 3'd3;
    localparam logic [2:0] REG_SRC_LATERAL  = 3'd4;
    localparam logic [2:0] REG_SRC_DEPTH    = 3'd5;
    localparam logic [2:0] REG_LAT_STEP     = 3'd6;
    localparam logic [2:0] REG_DEP_STEP     = 3'd7;

    // Configuration registers.
    logic [10:0] r_grid_depth;
    logic [10:0] r_grid_lateral;
    logic [9:0]  r_sponge_width;
    logic [15:0] r_taper_rate;
    logic [9:0]  r_src_lateral;
    logic [9:0]  r_src_depth;
    logic [23:0] r_lat_step;
    logic [23:0] r_dep_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_depth   <= 11'd1024;
            r_grid_lateral <= 11'd1024;
            r_sponge_width <= '0;
            r_taper_rate   <= '0;
            r_src_lateral  <= '0;
            r_src_depth    <= '0;
            r_lat_step     <= '0;
            r_dep_step     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRID_DEPTH:   r_grid_depth   <= i_cfg_data[10:0];
                REG_GRID_LATERAL: r_grid_lateral <= i_cfg_data[10:0];
                REG_SPONGE_WIDTH: r_sponge_width <= i_cfg_data[9:0];
                REG_TAPER_RATE:   r_taper_rate   <= i_cfg_data[15:0];
                REG_SRC_LATERAL:  r_src_lateral  <= i_cfg_data[9:0];
                REG_SRC_DEPTH:    r_src_depth    <= i_cfg_data[9:0];
                REG_LAT_STEP:     r_lat_step     <= i_cfg_data;
                REG_DEP_STEP:     r_dep_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic rate_nz;
    assign rate_nz = (r_taper_rate != 16'd0);

    // Global advance: the pipe moves unless a result waits in the output register and ready is low.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: border distance, edge term, source offsets.
    logic [10:0]        n_nz, n_nx;
    logic signed [11:0] n_iz, n_ix, n_ez, n_ex, n_edge, n_ke_full;
    logic               n_edge_on;
    logic [9:0]         n_dl, n_dd;

    always_comb begin
        n_nz = (r_grid_depth == 11'd0) ? 11'd1 :
               (r_grid_depth > 11'(MAX_GRID)) ? 11'(MAX_GRID) : r_grid_depth;
        n_nx = (r_grid_lateral == 11'd0) ? 11'd1 :
               (r_grid_lateral > 11'(MAX_GRID)) ? 11'(MAX_GRID) : r_grid_lateral;
        n_iz = $signed({2'b00, i_in_item.depth_index});
        n_ix = $signed({2'b00, i_in_item.lateral_index});
        n_ez = $signed({1'b0, n_nz}) - 12'sd1 - n_iz;
        n_ex = $signed({1'b0, n_nx}) - 12'sd1 - n_ix;
        n_edge = (n_iz < n_ix) ? n_iz : n_ix;
        if (n_ez < n_edge) begin
            n_edge = n_ez;
        end
        if (n_ex < n_edge) begin
            n_edge = n_ex;
        end
        n_edge_on = n_edge < $signed({2'b00, r_sponge_width});
        n_ke_full = $signed({2'b00, r_sponge_width}) - n_edge;
        n_dl = (i_in_item.lateral_index >= r_src_lateral) ?
               i_in_item.lateral_index - r_src_lateral : r_src_lateral - i_in_item.lateral_index;
        n_dd = (i_in_item.depth_index >= r_src_depth) ?
               i_in_item.depth_index - r_src_depth : r_src_depth - i_in_item.depth_index;
    end

    logic        r_v1, r_edge_on1;
    logic [10:0] r_ke1;
    logic [9:0]  r_dl1, r_dd1;
    t_side       r_side1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_edge_on1           <= n_edge_on;
            r_ke1                <= n_ke_full[10:0];
            r_dl1                <= n_dl;
            r_dd1                <= n_dd;
            r_side1.time_index   <= i_in_item.time_index;
            r_side1.start_delay  <= i_in_item.start_delay_in;
            r_side1.sample_value <= i_in_item.sample_value;
            r_side1.prior_value  <= i_in_item.prior_value;
            r_side1.accumulate   <= i_in_item.accumulate;
            r_side1.edge_coef    <= ONE_Q16;
        end
    end

    // Stage 2: scaled source offsets and square of the edge term.
    logic        r_v2, r_edge_on2;
    logic [21:0] r_ke2;
    logic [25:0] r_pl2, r_pd2;
    t_side       r_side2;
    logic [33:0] n_pl, n_pd;

    always_comb begin
        n_pl = 34'(r_dl1) * 34'(r_lat_step);
        n_pd = 34'(r_dd1) * 34'(r_dep_step);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_edge_on2 <= r_edge_on1;
            r_ke2      <= 22'(r_ke1) * 22'(r_ke1);
            r_pl2      <= n_pl[33:8];
            r_pd2      <= n_pd[33:8];
            r_side2    <= r_side1;
        end
    end

    // Stage 3: edge taper argument and squared offsets.
    logic        r_v3, r_edge_on3;
    logic [37:0] r_ae3;
    logic [51:0] r_sl3, r_sd3;
    t_side       r_side3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_edge_on3 <= r_edge_on2;
            r_ae3      <= 38'(r_taper_rate) * 38'(r_ke2);
            r_sl3      <= 52'(r_pl2) * 52'(r_pl2);
            r_sd3      <= 52'(r_pd2) * 52'(r_pd2);
            r_side3    <= r_side2;
        end
    end

    // Stage 4: edge taper lookup and squared source distance.
    logic               r_v4;
    logic [SQ_IN_W-1:0] r_s4;
    t_side              r_side4;
    t_side              n_side4;

    always_comb begin
        n_side4 = r_side3;
        if (r_edge_on3) begin
            n_side4.edge_coef = taper_lookup(r_ae3, 1'b0, rate_nz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4    <= SQ_IN_W'(r_sl3) + SQ_IN_W'(r_sd3);
            r_side4 <= n_side4;
        end
    end

    // Square-root pipeline gives the source distance in Q.8.
    logic                sq_valid;
    logic [SQ_RT_W-1:0]  sq_root;
    t_side               sq_side;

    scm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v4),
        .i_radicand (r_s4),
        .i_side     (r_side4),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // Stage 5: onset time and causal distance term.
    logic [20:0] n_onset, n_kc;
    logic        n_causal_on;

    always_comb begin
        n_onset     = 21'(sq_side.start_delay) + 21'(sq_root[SQ_RT_W-1:8]);
        n_causal_on = 21'(sq_side.time_index) < n_onset;
        n_kc        = n_onset - 21'(sq_side.time_index);
    end

    logic        r_v5, r_con5, r_big5;
    logic [10:0] r_kc5;
    t_side       r_side5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_con5  <= n_causal_on;
            r_big5  <= n_kc[20:11] != 10'd0;
            r_kc5   <= n_kc[10:0];
            r_side5 <= sq_side;
        end
    end

    // Stage 6: square of the causal term.
    logic        r_v6, r_con6, r_big6;
    logic [21:0] r_kc6;
    t_side       r_side6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_con6  <= r_con5;
            r_big6  <= r_big5;
            r_kc6   <= 22'(r_kc5) * 22'(r_kc5);
            r_side6 <= r_side5;
        end
    end

    // Stage 7: causal taper argument.
    logic        r_v7, r_con7, r_big7;
    logic [37:0] r_ac7;
    t_side       r_side7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_con7  <= r_con6;
            r_big7  <= r_big6;
            r_ac7   <= 38'(r_taper_rate) * 38'(r_kc6);
            r_side7 <= r_side6;
        end
    end

    // Stage 8: causal taper lookup.
    logic        r_v8, r_con8;
    logic [16:0] r_tc8;
    t_side       r_side8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_con8  <= r_con7;
            r_tc8   <= taper_lookup(r_ac7, r_big7, rate_nz);
            r_side8 <= r_side7;
        end
    end

    // Stage 9: combined coefficient, rounded product of the two tapers inside the causal zone, else the edge taper.
    logic [33:0] n_cprod;
    logic [16:0] n_coef;

    always_comb begin
        n_cprod = 34'(r_side8.edge_coef) * 34'(r_tc8) + 34'(HALF_Q16);
        n_coef  = r_con8 ? n_cprod[32:16] : r_side8.edge_coef;
    end

    logic        r_v9;
    logic [16:0] r_c9;
    t_side       r_side9;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c9    <= n_coef;
            r_side9 <= r_side8;
        end
    end

    // Stage 10: sample times coefficient.
    logic               r_v10;
    logic signed [49:0] r_prod10;
    logic [16:0]        r_c10;
    t_side              r_side10;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod10 <= 50'(r_side9.sample_value) * $signed({1'b0, r_c9});
            r_c10    <= r_c9;
            r_side10 <= r_side9;
        end
    end

    // Stage 11: rounding, optional accumulate and saturation into the output register.
    logic signed [49:0] n_rnd;
    logic signed [34:0] n_q, n_res;
    logic signed [31:0] n_sat;

    always_comb begin
        n_rnd = (r_prod10 + 50'sd32768) >>> 16;
        n_q   = n_rnd[34:0];
        n_res = r_side10.accumulate ? n_q + 35'(r_side10.prior_value) : n_q;
        if (n_res > 35'sd2147483647) begin
            n_sat = 32'sh7FFFFFFF;
        end else if (n_res < -35'sd2147483648) begin
            n_sat = 32'sh80000000;
        end else begin
            n_sat = n_res[31:0];
        end
    end

    logic r_v11;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_item.masked_value     <= n_sat;
            o_out_item.mask_coefficient <= r_c10;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else if (en) begin
            r_v1  <= i_in_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= sq_valid;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
        end
    end

    assign o_out_valid = r_v11;

`ifndef SYNTHESIS
    // The combined coefficient never exceeds one.
    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.mask_coefficient <= ONE_Q16))
        else $error("mask coefficient above one");

    // With a zero taper rate every taper reads the first table entry.
    a_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !rate_nz) |-> (o_out_item.mask_coefficient == ONE_Q16))
        else $error("coefficient not one at zero taper rate");

    // A frozen pipeline keeps the waiting result.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
